// ===== src/space_to_tab_entab_assert.svh =====
// ----------------------------------------------------------------------------
// space_to_tab_entab assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPACE_TO_TAB_ENTAB_ASSERT_SVH
`define SPACE_TO_TAB_ENTAB_ASSERT_SVH

// same-cycle implication
`define AST_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("entab assertion failed");

// next-cycle implication
`define AST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("entab assertion failed");

`endif

// ===== src/spte_pkg.sv =====
// ----------------------------------------------------------------------------
// spte_pkg
// types, constants and helpers shared by the entab block
// ----------------------------------------------------------------------------
package spte_pkg;

  localparam int COL_BITS   = 16;
  localparam int TW_BITS    = 7;
  localparam int CODE_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int START_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 1;
  localparam int CNT_BITS   = $clog2(COL_BITS + 1);

  localparam logic [COL_BITS-1:0]   COL_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CODE_BITS-1:0]  CODE_SPACE = 16'h0020;
  localparam logic [CODE_BITS-1:0]  CODE_TAB   = 16'h0009;
  localparam logic [TW_BITS-1:0]    TW_RESET   = 7'd4;

  localparam logic [IDX_BITS-1:0] REG_TAB_WIDTH    = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_START_COLUMN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_TO,
    ST_DIV_FROM,
    ST_COL,
    ST_DIV_TAB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [COL_BITS-1:0] dividend;
    logic [TW_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [COL_BITS-1:0] quot;
    logic [TW_BITS-1:0]  rem;
  } div_rsp_t;

  function automatic logic [COUNT_BITS-1:0] sat_count(input logic [COL_BITS-1:0] v);
    if (v > COL_BITS'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return COUNT_BITS'(v);
  endfunction

  function automatic logic [COL_BITS-1:0] start_to_col(input logic [START_BITS-1:0] v);
    if (32'(v) > 32'(COL_MAX)) begin
      return COL_MAX;
    end
    return COL_BITS'(v);
  endfunction

  function automatic logic [COL_BITS-1:0] col_add(input logic [COL_BITS-1:0] col,
                                                  input logic [TW_BITS-1:0] inc);
    logic [COL_BITS:0] sum;
    sum = {1'b0, col} + (COL_BITS + 1)'(inc);
    if (sum[COL_BITS]) begin
      return COL_MAX;
    end
    return sum[COL_BITS-1:0];
  endfunction

endpackage

// ===== src/spte_char_if.sv =====
// ----------------------------------------------------------------------------
// spte_char_if
// input channel carrying one code unit and its tags per transfer
// ----------------------------------------------------------------------------
interface spte_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        is_wide;
  logic        is_eol;
  logic        starts_text;

  modport source (output valid, char_code, is_wide, is_eol, starts_text, input ready);
  modport sink (input valid, char_code, is_wide, is_eol, starts_text, output ready);
endinterface

// ===== src/spte_result_if.sv =====
// ----------------------------------------------------------------------------
// spte_result_if
// output channel carrying one repeat-counted code unit per transfer
// ----------------------------------------------------------------------------
interface spte_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_code;
  logic [15:0] repeat_count;
  logic        last_of_burst;

  modport source (output valid, out_code, repeat_count, last_of_burst, input ready);
  modport sink (input valid, out_code, repeat_count, last_of_burst, output ready);
endinterface

// ===== src/spte_div.sv =====
// ----------------------------------------------------------------------------
// spte_div
// bit-serial restoring divider, column by tab width, one quotient bit a cycle
// ----------------------------------------------------------------------------
module spte_div
  import spte_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [CNT_BITS-1:0] cnt;
  logic                done;
  logic [COL_BITS-1:0] dq;
  logic [TW_BITS-1:0]  rem;
  logic [TW_BITS-1:0]  divisor;
  logic [TW_BITS:0]    trial;
  logic                ge;
  logic [TW_BITS-1:0]  rem_next;

  assign trial    = {rem, dq[COL_BITS-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? TW_BITS'(trial - {1'b0, divisor}) : trial[TW_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_BITS'(COL_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (cnt != '0) begin
      dq  <= {dq[COL_BITS-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dq;
  assign rsp.rem  = rem;

endmodule

// ===== src/space_to_tab_entab.sv =====
// ----------------------------------------------------------------------------
// space_to_tab_entab: one item at a time; a run flush needs two divisions on
// the shared bit-serial divider and a tab needs one, and the results of an item
// are offered one after another, each held while the output is stalled
// synchronous active-high reset clears the column, run state and registers
// ----------------------------------------------------------------------------
module space_to_tab_entab
  import spte_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  spte_char_if.sink           chars,
  spte_result_if.source       results
);

  state_t state, state_next;

  logic [TW_BITS-1:0]    tab_width, tab_width_next;
  logic [START_BITS-1:0] start_column, start_column_next;
  logic [COL_BITS-1:0]   column, column_next;
  logic                  run_active, run_active_next;
  logic [COL_BITS-1:0]   run_start, run_start_next;
  logic                  last_space, last_space_next;

  logic [CODE_BITS-1:0]  code_q, code_q_next;
  logic                  wide_q, wide_q_next;
  logic                  eol_q, eol_q_next;
  logic                  starts_q, starts_q_next;

  logic [COL_BITS-1:0]   q_to, q_to_next;
  logic [TW_BITS-1:0]    r_to, r_to_next;
  logic                  pend_tab, pend_tab_next;
  logic                  pend_sp, pend_sp_next;
  logic                  pend_ch, pend_ch_next;
  logic [COUNT_BITS-1:0] tab_cnt, tab_cnt_next;
  logic [COUNT_BITS-1:0] sp_cnt, sp_cnt_next;

  logic                  o_valid, o_valid_next;
  logic [CODE_BITS-1:0]  o_code, o_code_next;
  logic [COUNT_BITS-1:0] o_count, o_count_next;
  logic                  o_last, o_last_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                accept;
  logic [TW_BITS-1:0]  tw_eff;
  logic                blank_q;
  logic                flush_req;
  logic [COL_BITS-1:0] run_len;
  logic                run_nonempty;
  logic                single_space;
  logic [COL_BITS-1:0] col_base;
  logic                out_free;
  logic [COL_BITS-1:0] tabs;
  logic                any_pend;
  logic                more_pend;

  spte_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign chars.ready   = (state == ST_IDLE);
  assign accept        = chars.valid && chars.ready;
  assign tw_eff        = (tab_width == '0) ? TW_BITS'(1) : tab_width;
  assign blank_q       = (code_q == CODE_SPACE) || (code_q == CODE_TAB);
  assign flush_req     = run_active && (starts_q || eol_q || !blank_q);
  assign run_len       = column - run_start;
  assign run_nonempty  = column > run_start;
  assign single_space  = (run_len == COL_BITS'(1)) && last_space;
  assign col_base      = starts_q ? start_to_col(start_column) : column;
  assign out_free      = !o_valid || results.ready;
  assign tabs          = q_to - div_rsp.quot;
  assign any_pend      = pend_tab || pend_sp || pend_ch;
  assign more_pend     = pend_tab ? (pend_sp || pend_ch) : (pend_sp ? pend_ch : 1'b0);

  assign results.valid         = o_valid;
  assign results.out_code      = o_code;
  assign results.repeat_count  = o_count;
  assign results.last_of_burst = o_last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (flush_req && run_nonempty && !single_space) begin
          state_next = ST_DIV_TO;
        end else begin
          state_next = ST_COL;
        end
      end
      ST_DIV_TO: begin
        if (div_rsp.done) begin
          state_next = ST_DIV_FROM;
        end
      end
      ST_DIV_FROM: begin
        if (div_rsp.done) begin
          state_next = ST_COL;
        end
      end
      ST_COL: begin
        if (!eol_q && code_q == CODE_TAB) begin
          state_next = ST_DIV_TAB;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV_TAB: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!any_pend || (out_free && !more_pend)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tab_width_next    = tab_width;
    start_column_next = start_column;
    column_next       = column;
    run_active_next   = run_active;
    run_start_next    = run_start;
    last_space_next   = last_space;
    code_q_next       = code_q;
    wide_q_next       = wide_q;
    eol_q_next        = eol_q;
    starts_q_next     = starts_q;
    q_to_next         = q_to;
    r_to_next         = r_to;
    pend_tab_next     = pend_tab;
    pend_sp_next      = pend_sp;
    pend_ch_next      = pend_ch;
    tab_cnt_next      = tab_cnt;
    sp_cnt_next       = sp_cnt;
    o_valid_next      = o_valid && !results.ready;
    o_code_next       = o_code;
    o_count_next      = o_count;
    o_last_next       = o_last;
    div_req.start     = 1'b0;
    div_req.dividend  = column;
    div_req.divisor   = tw_eff;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TAB_WIDTH:    tab_width_next    = cfg_data[TW_BITS-1:0];
        REG_START_COLUMN: start_column_next = cfg_data[START_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          code_q_next   = chars.char_code;
          wide_q_next   = chars.is_wide;
          eol_q_next    = chars.is_eol;
          starts_q_next = chars.starts_text;
          pend_tab_next = 1'b0;
          pend_sp_next  = 1'b0;
          pend_ch_next  = 1'b0;
        end
      end
      ST_START: begin
        pend_ch_next = eol_q || !blank_q;
        if (flush_req) begin
          run_active_next = 1'b0;
          if (run_nonempty && single_space) begin
            pend_sp_next = 1'b1;
            sp_cnt_next  = COUNT_BITS'(1);
          end else if (run_nonempty) begin
            div_req.start    = 1'b1;
            div_req.dividend = column;
          end
        end
      end
      ST_DIV_TO: begin
        if (div_rsp.done) begin
          q_to_next        = div_rsp.quot;
          r_to_next        = div_rsp.rem;
          div_req.start    = 1'b1;
          div_req.dividend = run_start;
        end
      end
      ST_DIV_FROM: begin
        if (div_rsp.done) begin
          if (tabs != '0) begin
            pend_tab_next = 1'b1;
            tab_cnt_next  = sat_count(tabs);
            pend_sp_next  = r_to != '0;
            sp_cnt_next   = COUNT_BITS'(r_to);
          end else begin
            pend_sp_next = 1'b1;
            sp_cnt_next  = sat_count(run_len);
          end
        end
      end
      ST_COL: begin
        if (eol_q) begin
          column_next = '0;
        end else if (blank_q) begin
          if (!run_active) begin
            run_active_next = 1'b1;
            run_start_next  = col_base;
          end
          if (code_q == CODE_SPACE) begin
            column_next     = col_add(col_base, TW_BITS'(1));
            last_space_next = 1'b1;
          end else begin
            column_next      = col_base;
            last_space_next  = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = col_base;
          end
        end else begin
          column_next = col_add(col_base, wide_q ? TW_BITS'(2) : TW_BITS'(1));
        end
      end
      ST_DIV_TAB: begin
        if (div_rsp.done) begin
          column_next = col_add(column, tw_eff - div_rsp.rem);
        end
      end
      ST_OUT: begin
        if (any_pend && out_free) begin
          o_valid_next = 1'b1;
          o_last_next  = !more_pend;
          if (pend_tab) begin
            o_code_next   = CODE_TAB;
            o_count_next  = tab_cnt;
            pend_tab_next = 1'b0;
          end else if (pend_sp) begin
            o_code_next  = CODE_SPACE;
            o_count_next = sp_cnt;
            pend_sp_next = 1'b0;
          end else begin
            o_code_next  = code_q;
            o_count_next = COUNT_BITS'(1);
            pend_ch_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tab_width    <= TW_RESET;
      start_column <= '0;
      column       <= '0;
      run_active   <= 1'b0;
      run_start    <= '0;
      last_space   <= 1'b0;
      pend_tab     <= 1'b0;
      pend_sp      <= 1'b0;
      pend_ch      <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      tab_width    <= tab_width_next;
      start_column <= start_column_next;
      column       <= column_next;
      run_active   <= run_active_next;
      run_start    <= run_start_next;
      last_space   <= last_space_next;
      pend_tab     <= pend_tab_next;
      pend_sp      <= pend_sp_next;
      pend_ch      <= pend_ch_next;
      o_valid      <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    code_q   <= code_q_next;
    wide_q   <= wide_q_next;
    eol_q    <= eol_q_next;
    starts_q <= starts_q_next;
    q_to     <= q_to_next;
    r_to     <= r_to_next;
    tab_cnt  <= tab_cnt_next;
    sp_cnt   <= sp_cnt_next;
    o_code   <= o_code_next;
    o_count  <= o_count_next;
    o_last   <= o_last_next;
  end

endmodule

// ===== src/spte_chk.sv =====
// ----------------------------------------------------------------------------
// spte_chk
// port-level checks on the entab block, bound to the top level
// ----------------------------------------------------------------------------
`include "space_to_tab_entab_assert.svh"

module spte_chk
  import spte_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CODE_BITS-1:0]  out_code,
  input logic [COUNT_BITS-1:0] repeat_count,
  input logic                  last_of_burst
);

  // one item in flight at a time
  `AST_NXT(a_one_item, in_valid && in_ready, !in_ready)

  // a result never stands for zero copies
  `AST_IMP(a_count_nonzero, out_valid, repeat_count != '0)

  // only tabs and spaces precede the last result of a burst
  `AST_IMP(a_blank_lead, out_valid && !last_of_burst, out_code == CODE_TAB || out_code == CODE_SPACE)

  // nothing offered straight out of reset
  `AST_IMP(a_reset_quiet, $past(rst), !out_valid)

  // stalled transfer holds
  `AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_code) && $stable(repeat_count))

endmodule

bind space_to_tab_entab spte_chk u_spte_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (chars.valid),
  .in_ready      (chars.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_code      (results.out_code),
  .repeat_count  (results.repeat_count),
  .last_of_burst (results.last_of_burst)
);
